[sv/wisp_pkg.sv]
// Package with shared constants and types for the WLAN IE security parser.
package wisp_pkg;
  localparam int SsidBytesDefault = 32;
  localparam logic [31:0] SuiteTkip = 32'h000FAC02;
  localparam logic [31:0] SuiteCcmp = 32'h000FAC04;
  localparam logic [7:0] TypeSsid = 8'd0;
  localparam logic [7:0] TypeRsn = 8'd48;
  localparam logic [7:0] TypeVendor = 8'd221;
  localparam logic [23:0] OuiMs = 24'h0050F2;
  localparam logic [7:0] VendorWpa = 8'd1;
  localparam logic [7:0] VendorWps = 8'd4;
  localparam int FWpa = 0;
  localparam int FWps = 1;
  localparam int FPsk = 2;
  localparam int FPtkip = 3;
  localparam int FPccmp = 4;
  localparam int FGtkip = 5;
  localparam int FGccmp = 6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [7:0] ssid_char;
    logic [4:0] ssid_pos;
    logic [5:0] ssid_length;
    logic       ssid_found;
    logic       wpa_flag;
    logic       wps_flag;
    logic       rsn_psk_flag;
    logic       pair_tkip_flag;
    logic       pair_ccmp_flag;
    logic       group_tkip_flag;
    logic       group_ccmp_flag;
    logic       run_last;
  } out_item_t;
endpackage

[sv/wisp_if.sv]
// Valid/ready channel interface carrying one payload item.
interface wisp_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[sv/wlan_ie_security_parser_top.sv]
// Top level of the WLAN information-element security parser.
// Each byte transaction is parsed as it is accepted; one input per cycle is accepted while parsing.
// At end of buffer the block passes through a read state for the SSID RAM, then emits
// max(1, SSID length) results, one per cycle while the output is ready; input is held off
// until the cycle after the last result transaction; the first result follows the read state.
// Synchronous active-high reset clears parse and run state, not the output registers or SSID RAM.
module wlan_ie_security_parser_top #(
  parameter int SSID_BYTES = wisp_pkg::SsidBytesDefault
) (
  input logic clk,
  input logic rst,
  wisp_if.sink   in_ch,
  wisp_if.source out_ch
);
  import wisp_pkg::*;

  localparam int PW = (SSID_BYTES > 1) ? $clog2(SSID_BYTES) : 1;
  localparam int AW = PW + 1;

  typedef enum logic [1:0] {PH_TYPE, PH_LEN, PH_PAY} phase_t;
  typedef enum logic [1:0] {S_PARSE, S_READ, S_EMIT} run_t;

  phase_t     phase;
  run_t       run;
  logic [7:0] etype, elen, eoff;
  logic [31:0] wsh;
  logic       ver_ok;
  logic [15:0] pcnt, acnt;
  logic [6:0] pflags, cflags;
  logic       bank;
  logic [5:0] plen_ssid, clen_ssid;
  logic       cfound;
  logic [5:0] k, n;
  logic [5:0] olen;
  logic       ofound;
  logic [6:0] oflags;
  logic [4:0] opos;
  logic       olast, ovalid, zero_len;

  in_item_t  inp;
  assign inp = in_ch.payload;
  wire take = in_ch.valid && in_ch.ready;

  logic          ram_we;
  logic [AW-1:0] ram_wa, ram_ra;
  logic [7:0]    ram_rd;

  wisp_ram #(.Width(8), .Depth(2 ** AW)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(inp.data_byte),
    .raddr(ram_ra), .rdata(ram_rd)
  );

  logic [7:0]  b;
  logic [31:0] w_next;
  logic [8:0]  o9;
  logic [17:0] pl4, r1;
  logic [17:0] r2;
  logic [6:0]  pf_next;
  logic        fin;
  logic [7:0]  off_next;

  always_comb begin
    b = inp.data_byte;
    w_next = {wsh[23:0], b};
    o9 = {1'b0, eoff};
    pl4 = {pcnt, 2'b00};
    r1 = 18'({1'b0, o9}) - 18'd8;
    r2 = 18'd0;
    pf_next = pflags;
    off_next = eoff + 8'd1;
    fin = 1'b0;
    ram_we = 1'b0;
    ram_wa = {~bank, eoff[PW-1:0]};
    if (take && inp.has_byte && phase == PH_PAY) begin
      fin = (off_next == elen);
      if (etype == TypeSsid) begin
        ram_we = (32'(eoff) < SSID_BYTES);
      end else if (etype == TypeVendor) begin
        if (eoff == 8'd3 && w_next[31:8] == OuiMs) begin
          if (w_next[7:0] == VendorWpa) pf_next[FWpa] = 1'b1;
          else if (w_next[7:0] == VendorWps) pf_next[FWps] = 1'b1;
        end
      end else if (etype == TypeRsn && ver_ok && eoff != 8'd1) begin
        if (eoff == 8'd5) begin
          if (w_next == SuiteTkip) pf_next[FGtkip] = 1'b1;
          else if (w_next == SuiteCcmp) pf_next[FGccmp] = 1'b1;
        end else if (eoff >= 8'd8) begin
          if (r1 < pl4) begin
            if (r1[1:0] == 2'd3) begin
              if (w_next == SuiteTkip) pf_next[FPtkip] = 1'b1;
              else if (w_next == SuiteCcmp) pf_next[FPccmp] = 1'b1;
            end
          end else if (18'({1'b0, o9}) >= pl4 + 18'd10) begin
            r2 = 18'({1'b0, o9}) - pl4 - 18'd10;
            if (r2 < {acnt, 2'b00} && r2[1:0] == 2'd3 && w_next == SuiteTkip)
              pf_next[FPsk] = 1'b1;
          end
        end
      end
    end
  end

  // The read address runs one position ahead of the presented result; while stalled it points at the presented result.
  assign ram_ra = {bank, (run == S_EMIT && !out_ch.ready) ? opos[PW-1:0] : k[PW-1:0]};
  assign in_ch.ready = (run == S_PARSE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TYPE; run <= S_PARSE; etype <= '0; elen <= '0; eoff <= '0;
      wsh <= '0; ver_ok <= 1'b0; pcnt <= '0; acnt <= '0; pflags <= '0;
      cflags <= '0; bank <= 1'b0; plen_ssid <= '0; clen_ssid <= '0;
      cfound <= 1'b0; k <= '0; n <= '0; ovalid <= 1'b0;
    end else begin
      unique case (run)
        S_PARSE: begin
          if (take) begin
            if (inp.has_byte) begin
              unique case (phase)
                PH_TYPE: begin
                  etype <= b; phase <= PH_LEN;
                end
                PH_LEN: begin
                  elen <= b; eoff <= '0; wsh <= '0; ver_ok <= 1'b0; pcnt <= '0;
                  acnt <= '0; pflags <= '0; plen_ssid <= '0;
                  phase <= (b == 8'd0) ? PH_TYPE : PH_PAY;
                  if (b == 8'd0 && etype == TypeSsid) begin
                    bank <= ~bank; clen_ssid <= '0; cfound <= 1'b1;
                  end
                end
                default: begin
                  wsh <= w_next; eoff <= off_next; pflags <= pf_next;
                  if (etype == TypeSsid && ram_we && b != 8'd0)
                    plen_ssid <= 6'(eoff) + 6'd1;
                  if (etype == TypeRsn) begin
                    if (eoff == 8'd1) ver_ok <= (wsh[7:0] == 8'd1) && (b == 8'd0);
                    else if (ver_ok && eoff == 8'd7) pcnt <= {b, wsh[7:0]};
                    else if (ver_ok && eoff >= 8'd8 && !(r1 < pl4)
                             && 18'({1'b0, o9}) == pl4 + 18'd9)
                      acnt <= {b, wsh[7:0]};
                  end
                  if (fin) begin
                    phase <= PH_TYPE;
                    if (etype == TypeSsid) begin
                      bank <= ~bank; cfound <= 1'b1;
                      clen_ssid <= (ram_we && b != 8'd0) ? 6'(eoff) + 6'd1 : plen_ssid;
                    end else if (etype == TypeRsn || etype == TypeVendor) begin
                      cflags <= cflags | pf_next;
                    end
                  end
                end
              endcase
            end
            if (inp.end_of_buffer) run <= S_READ;
          end
          k <= '0;
        end
        S_READ: begin
          n <= (clen_ssid == 6'd0) ? 6'd1 : clen_ssid;
          zero_len <= (clen_ssid == 6'd0);
          olen <= clen_ssid; ofound <= cfound; oflags <= cflags;
          k <= 6'd1;
          opos <= '0;
          olast <= (clen_ssid <= 6'd1);
          ovalid <= 1'b1;
          run <= S_EMIT;
        end
        default: begin
          if (out_ch.ready) begin
            if (olast) begin
              ovalid <= 1'b0; run <= S_PARSE;
              phase <= PH_TYPE; etype <= '0; elen <= '0; eoff <= '0; wsh <= '0;
              ver_ok <= 1'b0; pcnt <= '0; acnt <= '0; pflags <= '0; cflags <= '0;
              bank <= 1'b0; plen_ssid <= '0; clen_ssid <= '0; cfound <= 1'b0;
              k <= '0;
            end else begin
              k <= k + 6'd1;
              opos <= 5'(k);
              olast <= (k == n - 6'd1);
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    out_ch.valid = ovalid;
    out_ch.payload.ssid_char = zero_len ? 8'd0 : ram_rd;
    out_ch.payload.ssid_pos = opos;
    out_ch.payload.ssid_length = olen;
    out_ch.payload.ssid_found = ofound;
    out_ch.payload.wpa_flag = oflags[FWpa];
    out_ch.payload.wps_flag = oflags[FWps];
    out_ch.payload.rsn_psk_flag = oflags[FPsk];
    out_ch.payload.pair_tkip_flag = oflags[FPtkip];
    out_ch.payload.pair_ccmp_flag = oflags[FPccmp];
    out_ch.payload.group_tkip_flag = oflags[FGtkip];
    out_ch.payload.group_ccmp_flag = oflags[FGccmp];
    out_ch.payload.run_last = olast;
  end

  a_no_in_during_run: assert property (@(posedge clk) disable iff (rst)
    run != S_PARSE |-> !in_ch.ready) else $error("input taken during run");
  a_valid_in_emit: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> run == S_EMIT) else $error("output valid outside run");
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    clen_ssid <= 6'(SSID_BYTES)) else $error("ssid length out of range");
endmodule

[sv/wisp_ram.sv]
// Generic single-port-write, registered-read RAM.
module wisp_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
